### hdl/rpru_pkg.sv
// Shared types and constants for the RAID parity recover and unpack block.
package rpru_pkg;

  // Fixed field widths
  localparam int CELL_W      = 2;
  localparam int NUM_CELLS   = 6;
  localparam int DISK_W      = 3;
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int DIGIT_W     = 4;
  localparam int FILL_W      = 3;
  localparam int MAX_RESULTS = 40;
  localparam int RES_W       = $clog2(MAX_RESULTS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_COUNT  = 2'd0,
    REG_PARITY_ODD  = 2'd1,
    REG_BLOCK_BITS  = 2'd2,
    REG_BLOCK_COUNT = 2'd3
  } rpru_cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_FAIL
  } rpru_state_t;

  // Raw configuration register contents
  typedef struct packed {
    logic [DISK_W-1:0] disk_count;
    logic              parity_odd;
    logic [CFG_W-1:0]  block_bits;
    logic [CFG_W-1:0]  block_count;
  } rpru_cfg_t;

  // One column of cells, disk 0 in the lowest slot
  typedef logic [NUM_CELLS-1:0][CELL_W-1:0] rpru_cells_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic drain_start;
    logic drain_run;
    logic fail_emit;
  } rpru_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic set_done;
    logic set_bad;
    logic drain_done;
    logic out_busy;
  } rpru_sts_t;

endpackage

### hdl/raid_parity_recover_unpack.sv
// One column per cycle while loading; an invalid set reports through the fail state and
// the output register after its last column. A valid set then drains one data bit per
// cycle from the column memory's single read port, (disks-1) * block_bits * block_count
// bits capped at forty digits; no columns are taken during the drain. Output stalls freeze the drain.
// Reset clears control state and restores register defaults; the column memory is not cleared.
module raid_parity_recover_unpack #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_DISKS   = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [rpru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpru_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk0,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk1,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk2,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk3,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk4,
  input  logic [rpru_pkg::CELL_W-1:0]     cell_disk5,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            set_ok,
  output logic [rpru_pkg::DIGIT_W-1:0]    hex_digit,
  output logic                            last_digit
);
  import rpru_pkg::*;

  rpru_cfg_t   cfg;
  rpru_cells_t cells;
  rpru_cmd_t   cmd;
  rpru_sts_t   sts;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disk_count  <= DISK_W'(6);
      cfg.parity_odd  <= 1'b0;
      cfg.block_bits  <= CFG_W'(4);
      cfg.block_count <= CFG_W'(8);
    end else if (cfg_en) begin
      unique case (rpru_cfg_reg_t'(cfg_index))
        REG_DISK_COUNT:  cfg.disk_count  <= cfg_data[DISK_W-1:0];
        REG_PARITY_ODD:  cfg.parity_odd  <= cfg_data[0];
        REG_BLOCK_BITS:  cfg.block_bits  <= cfg_data;
        REG_BLOCK_COUNT: cfg.block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cells = {cell_disk5, cell_disk4, cell_disk3, cell_disk2, cell_disk1, cell_disk0};

  rpru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpru_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_DISKS   (MAX_DISKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cells      (cells),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .set_ok     (set_ok),
    .hex_digit  (hex_digit),
    .last_digit (last_digit)
  );

endmodule

### hdl/rpru_ctrl.sv
// Controller state machine: column loading, digit drain and invalid-set report.
module rpru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpru_pkg::rpru_sts_t sts,
  output rpru_pkg::rpru_cmd_t cmd
);
  import rpru_pkg::*;

  rpru_state_t state;
  rpru_state_t state_next;
  logic        accept;

  assign accept = (state == ST_LOAD) && in_valid;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && sts.set_done) begin
          state_next = sts.set_bad ? ST_FAIL : ST_DRAIN;
        end
      end
      ST_FAIL: begin
        if (!sts.out_busy) begin
          state_next = ST_LOAD;
        end
      end
      ST_DRAIN: begin
        if (sts.drain_done) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall        = 1'b1;
    cmd.load        = 1'b0;
    cmd.drain_start = 1'b0;
    cmd.drain_run   = 1'b0;
    cmd.fail_emit   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_stall        = 1'b0;
        cmd.load        = accept;
        cmd.drain_start = accept && sts.set_done && !sts.set_bad;
      end
      ST_FAIL: begin
        cmd.fail_emit = !sts.out_busy;
      end
      ST_DRAIN: begin
        cmd.drain_run = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

### hdl/rpru_dp.sv
// Datapath: column parity check and rebuild, column memory, bit sequencer, digit packing.
module rpru_dp #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_DISKS   = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpru_pkg::rpru_cfg_t           cfg,
  input  rpru_pkg::rpru_cells_t         cells,
  input  rpru_pkg::rpru_cmd_t           cmd,
  output rpru_pkg::rpru_sts_t           sts,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          set_ok,
  output logic [rpru_pkg::DIGIT_W-1:0]  hex_digit,
  output logic                          last_digit
);
  import rpru_pkg::*;

  localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int PROD_W = 2 * CFG_W;

  // Largest block count for each block size
  logic [CFG_W-1:0] lim_tab [2**CFG_W];
  for (genvar g = 0; g < 2**CFG_W; g++) begin : g_lim
    localparam int LIM = MAX_COLUMNS / ((g == 0) ? 1 : g);
    assign lim_tab[g] = CFG_W'(LIM);
  end

  // Effective geometry
  logic [DISK_W-1:0] eff_d;
  logic [CFG_W-1:0]  eff_s;
  logic [CFG_W-1:0]  eff_b;
  logic [CFG_W-1:0]  lim;
  logic [PROD_W-1:0] total;

  always_comb begin
    eff_d = cfg.disk_count;
    if (eff_d < DISK_W'(2)) begin
      eff_d = DISK_W'(2);
    end else if (eff_d > DISK_W'(MAX_DISKS)) begin
      eff_d = DISK_W'(MAX_DISKS);
    end
    eff_s = cfg.block_bits;
    if (eff_s == '0) begin
      eff_s = CFG_W'(1);
    end else if (eff_s > CFG_W'(MAX_COLUMNS)) begin
      eff_s = CFG_W'(MAX_COLUMNS);
    end
    lim   = lim_tab[eff_s];
    eff_b = cfg.block_count;
    if (eff_b == '0) begin
      eff_b = CFG_W'(1);
    end
    if (eff_b > lim) begin
      eff_b = lim;
    end
    total = PROD_W'(eff_s) * PROD_W'(eff_b);
  end

  // Column check and rebuild
  logic [CNT_W-1:0]     count;
  logic [CNT_W:0]       count_inc;
  logic                 set_valid;
  logic                 valid_next;
  logic [MAX_DISKS-1:0] unk;
  logic [MAX_DISKS-1:0] kb;
  logic [MAX_DISKS-1:0] col_bits;
  logic                 kx;
  logic                 fix;
  logic                 none_unk;
  logic                 one_unk;

  always_comb begin
    for (int i = 0; i < MAX_DISKS; i++) begin
      unk[i] = 1'b0;
      kb[i]  = 1'b0;
      if (DISK_W'(i) < eff_d) begin
        unk[i] = cells[i][1];
        kb[i]  = !cells[i][1] && cells[i][0];
      end
    end
    kx       = ^kb;
    fix      = kx ^ cfg.parity_odd;
    none_unk = (unk == '0);
    one_unk  = $onehot(unk);
    valid_next = set_valid;
    if (set_valid) begin
      if (!none_unk && !one_unk) begin
        valid_next = 1'b0;
      end else if (none_unk && (kx != cfg.parity_odd)) begin
        valid_next = 1'b0;
      end
    end
    col_bits = kb | ((set_valid && one_unk && fix) ? unk : '0);
  end

  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);

  // Track columns of the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      set_valid <= 1'b1;
    end else if (cmd.load) begin
      if (sts.set_done) begin
        count     <= '0;
        set_valid <= 1'b1;
      end else begin
        count     <= count_inc[CNT_W-1:0];
        set_valid <= valid_next;
      end
    end
  end

  // Drain sequencer, stage A: stripe, disk and bit position
  logic                 freeze;
  logic                 step;
  logic                 a_valid;
  logic [CFG_W-1:0]     a_i;
  logic [DISK_W-1:0]    a_j;
  logic [CFG_W-1:0]     a_k;
  logic [CFG_W-1:0]     a_base;
  logic [DISK_W-1:0]    a_p;
  logic [DISK_W-1:0]    j1;
  logic [DISK_W-1:0]    j_nx;
  logic [DISK_W-1:0]    last_j;
  logic [DISK_W-1:0]    p_nx;
  logic                 k_end;
  logic                 j_end;
  logic                 i_end;
  logic                 a_last;
  logic [CFG_W-1:0]     rd_sum;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;

  assign freeze = out_valid && out_stall;
  assign step   = cmd.drain_run && !freeze;

  always_comb begin
    j1      = a_j + DISK_W'(1);
    j_nx    = (j1 == a_p) ? j1 + DISK_W'(1) : j1;
    last_j  = (a_p == eff_d - DISK_W'(1)) ? eff_d - DISK_W'(2) : eff_d - DISK_W'(1);
    p_nx    = (a_p == eff_d - DISK_W'(1)) ? '0 : a_p + DISK_W'(1);
    k_end   = (a_k == eff_s - CFG_W'(1));
    j_end   = (a_j == last_j);
    i_end   = (a_i == eff_b - CFG_W'(1));
    a_last  = k_end && j_end && i_end;
    rd_sum  = a_base + a_k;
    rd_addr = rd_sum[ADDR_W-1:0];
    rd_en   = step && a_valid;
  end

  // Stage C signals used for early termination
  logic [DIGIT_W-1:0] acc;
  logic [FILL_W-1:0]  fill;
  logic [RES_W-1:0]   dig_cnt;
  logic               b_valid;
  logic [DISK_W-1:0]  b_j;
  logic               b_last;
  logic [MAX_DISKS-1:0] rd_data;
  logic [MAX_DISKS-1:0] rd_shift;
  logic               bit_val;
  logic [DIGIT_W-1:0] acc_new;
  logic [FILL_W-1:0]  fill_new;
  logic [DIGIT_W-1:0] digit;
  logic               emit_dig;
  logic               dig_last;
  logic               drain_done;

  always_comb begin
    rd_shift = rd_data >> b_j;
    bit_val  = rd_shift[0];
    acc_new  = {acc[DIGIT_W-2:0], bit_val};
    fill_new = fill + FILL_W'(1);
    case (fill_new)
      FILL_W'(1): digit = {acc_new[0], 3'b000};
      FILL_W'(2): digit = {acc_new[1:0], 2'b00};
      FILL_W'(3): digit = {acc_new[2:0], 1'b0};
      default:    digit = acc_new;
    endcase
    emit_dig   = step && b_valid && ((fill_new == FILL_W'(DIGIT_W)) || b_last);
    dig_last   = b_last || (dig_cnt == RES_W'(MAX_RESULTS - 1));
    drain_done = emit_dig && dig_last;
  end

  // Advance stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd.drain_start) begin
      a_valid <= 1'b1;
      a_i     <= '0;
      a_j     <= DISK_W'(1);
      a_k     <= '0;
      a_base  <= '0;
      a_p     <= '0;
    end else if (step) begin
      if (drain_done) begin
        a_valid <= 1'b0;
      end else if (a_valid) begin
        if (a_last) begin
          a_valid <= 1'b0;
        end
        if (!k_end) begin
          a_k <= a_k + CFG_W'(1);
        end else if (!j_end) begin
          a_k <= '0;
          a_j <= j_nx;
        end else begin
          a_k    <= '0;
          a_i    <= a_i + CFG_W'(1);
          a_base <= a_base + eff_s;
          a_p    <= p_nx;
          a_j    <= (p_nx == '0) ? DISK_W'(1) : '0;
        end
      end
    end
  end

  // Column memory: write on load, registered read during drain
  logic [MAX_DISKS-1:0] mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (cmd.load && ((CNT_W+1)'(count) < (CNT_W+1)'(MAX_COLUMNS))) begin
      mem[count[ADDR_W-1:0]] <= col_bits;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cmd.drain_start) begin
      b_valid <= 1'b0;
    end else if (step) begin
      if (drain_done) begin
        b_valid <= 1'b0;
      end else begin
        b_valid <= a_valid;
        if (a_valid) begin
          b_j    <= a_j;
          b_last <= a_last;
        end
      end
    end
  end

  // Pack bits into digits
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      fill    <= '0;
      dig_cnt <= '0;
    end else if (cmd.drain_start) begin
      acc     <= '0;
      fill    <= '0;
      dig_cnt <= '0;
    end else if (step && b_valid) begin
      if (emit_dig) begin
        acc     <= '0;
        fill    <= '0;
        dig_cnt <= drain_done ? '0 : dig_cnt + RES_W'(1);
      end else begin
        acc  <= acc_new;
        fill <= fill_new;
      end
    end
  end

  // Output register: load a digit or the invalid-set report
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!freeze) begin
      out_valid <= emit_dig || cmd.fail_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      if (emit_dig) begin
        set_ok     <= 1'b1;
        hex_digit  <= digit;
        last_digit <= dig_last;
      end else if (cmd.fail_emit) begin
        set_ok     <= 1'b0;
        hex_digit  <= '0;
        last_digit <= 1'b1;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.set_done   = (PROD_W'(count_inc) >= total);
    sts.set_bad    = !valid_next;
    sts.drain_done = drain_done;
    sts.out_busy   = freeze;
  end

endmodule
